// ===== hdl/cbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_pkg
// shared types and constants for the circle / box push-out pipeline
// ----------------------------------------------------------------------------
package cbp_pkg;

	localparam int COORD_FRAC_BITS = 12;

	localparam int CW       = 24;   // coordinate width
	localparam int RADIUS_W = 23;
	localparam int THR_W    = 25;
	localparam int CFG_W    = 25;
	localparam int CFG_IDX_W = 1;
	localparam int DIFF_W   = 25;   // coordinate difference
	localparam int SQ_W     = 48;   // one squared difference
	localparam int MSQ_W    = 46;   // squared length that can still hit
	localparam int LEN_W    = 23;   // root of the squared length
	localparam int Q_W      = 23;   // rounded scale of one component
	localparam int NUM_W    = 48;   // dividend of the rounding divide
	localparam int OFS_W    = 27;   // offset before clipping
	localparam int SQRT_STAGES = MSQ_W / 2;
	localparam int DIV_STAGES  = Q_W;

	localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(64'd1 << COORD_FRAC_BITS);
	localparam logic [THR_W-1:0]    THR_RST    =
		THR_W'((64'd1 << (2 * COORD_FRAC_BITS)) / 1000);

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THR    = 1'd1;

	localparam logic [1:0] SIDE_LEFT   = 2'd0;
	localparam logic [1:0] SIDE_RIGHT  = 2'd1;
	localparam logic [1:0] SIDE_BOTTOM = 2'd2;
	localparam logic [1:0] SIDE_TOP    = 2'd3;

	typedef struct packed {
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
		logic signed [CW-1:0] box_min_x;
		logic signed [CW-1:0] box_min_y;
		logic signed [CW-1:0] box_max_x;
		logic signed [CW-1:0] box_max_y;
	} in_word_t;

	typedef struct packed {
		logic                 hit;
		logic signed [CW-1:0] offset_x;
		logic signed [CW-1:0] offset_y;
		logic                 was_inside;
		logic [1:0]           push_side;
		logic                 saturated;
	} out_word_t;

	// per-item context that travels beside the root and divide stages
	typedef struct packed {
		logic                    hit;
		logic                    in_box;
		logic [1:0]              side;
		logic signed [CW-1:0]    vx;
		logic signed [CW-1:0]    vy;
		logic signed [OFS_W-1:0] ox_in;
		logic signed [OFS_W-1:0] oy_in;
	} ctx_t;

endpackage

// ===== hdl/cbp_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_ifs
// valid / ready channels for input and result words
// ----------------------------------------------------------------------------
interface cbp_item_if;
	logic             valid;
	logic             ready;
	cbp_pkg::in_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cbp_result_if;
	logic               valid;
	logic               ready;
	cbp_pkg::out_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/cbp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_front
// gap vector, squares, hit and inside tests, nearest side (three stages)
// ----------------------------------------------------------------------------
module cbp_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  cbp_pkg::in_word_t                 in_word,
	input  logic [cbp_pkg::RADIUS_W-1:0]      radius,
	input  logic [cbp_pkg::THR_W-1:0]         thr,
	output logic                              out_valid,
	output cbp_pkg::ctx_t                     out_ctx,
	output logic [cbp_pkg::MSQ_W-1:0]         out_msq
);

	localparam int DW = cbp_pkg::DIFF_W;
	localparam int OW = cbp_pkg::OFS_W;

	function automatic logic signed [DW-1:0] axis_gap(
		input logic signed [DW-1:0] p,
		input logic signed [DW-1:0] lo,
		input logic signed [DW-1:0] hi
	);
		logic signed [DW-1:0] g;
		if (p < lo) begin
			g = lo - p;
		end else if (p < hi) begin
			g = '0;
		end else begin
			g = hi - p;
		end
		return g;
	endfunction

	logic signed [DW-1:0] px, py, lx, ly, hx, hy;
	logic signed [DW-1:0] gx, gy;

	assign px = DW'(in_word.point_x);
	assign py = DW'(in_word.point_y);
	assign lx = DW'(in_word.box_min_x);
	assign ly = DW'(in_word.box_min_y);
	assign hx = DW'(in_word.box_max_x);
	assign hy = DW'(in_word.box_max_y);
	assign gx = axis_gap(px, lx, hx);
	assign gy = axis_gap(py, ly, hy);

	// stage 1: gap and side distances
	logic                 v_s1;
	logic signed [DW-1:0] vx_s1, vy_s1;
	logic signed [DW-1:0] d_s1 [0:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1   <= gx;
			vy_s1   <= gy;
			d_s1[0] <= px - lx;
			d_s1[1] <= hx - px;
			d_s1[2] <= py - ly;
			d_s1[3] <= hy - py;
		end
	end

	// stage 2: squares and nearest side push
	logic signed [2*DW-1:0] sqx, sqy;
	logic signed [DW-1:0]   best;
	logic [1:0]             side;
	logic signed [OW-1:0]   rad_e, ox_c, oy_c;

	assign sqx   = vx_s1 * vx_s1;
	assign sqy   = vy_s1 * vy_s1;
	assign rad_e = OW'({1'b0, radius});

	always_comb begin
		best = d_s1[0];
		side = cbp_pkg::SIDE_LEFT;
		if (d_s1[1] < best) begin
			best = d_s1[1];
			side = cbp_pkg::SIDE_RIGHT;
		end
		if (d_s1[2] < best) begin
			best = d_s1[2];
			side = cbp_pkg::SIDE_BOTTOM;
		end
		if (d_s1[3] < best) begin
			side = cbp_pkg::SIDE_TOP;
		end
		ox_c = '0;
		oy_c = '0;
		case (side)
			cbp_pkg::SIDE_LEFT:   ox_c = -OW'(d_s1[0]) - rad_e;
			cbp_pkg::SIDE_RIGHT:  ox_c = OW'(d_s1[1]) + rad_e;
			cbp_pkg::SIDE_BOTTOM: oy_c = -OW'(d_s1[2]) - rad_e;
			default:              oy_c = OW'(d_s1[3]) + rad_e;
		endcase
	end

	logic                          v_s2;
	logic [cbp_pkg::SQ_W-1:0]      sqx_s2, sqy_s2;
	logic signed [cbp_pkg::CW-1:0] vx_s2, vy_s2;
	logic [1:0]                    side_s2;
	logic signed [OW-1:0]          ox_s2, oy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2  <= sqx[cbp_pkg::SQ_W-1:0];
			sqy_s2  <= sqy[cbp_pkg::SQ_W-1:0];
			vx_s2   <= vx_s1[cbp_pkg::CW-1:0];
			vy_s2   <= vy_s1[cbp_pkg::CW-1:0];
			side_s2 <= side;
			ox_s2   <= ox_c;
			oy_s2   <= oy_c;
		end
	end

	// stage 3: squared length against radius squared and inside threshold
	logic [2*cbp_pkg::RADIUS_W-1:0] rsq_q;
	logic [cbp_pkg::SQ_W:0]         msq;
	logic                           hit_c, inside_c;

	always_ff @(posedge clk) begin
		rsq_q <= radius * radius;
	end

	assign msq      = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign hit_c    = msq < (cbp_pkg::SQ_W + 1)'(rsq_q);
	assign inside_c = msq < (cbp_pkg::SQ_W + 1)'(thr);

	logic                      v_s3;
	cbp_pkg::ctx_t             ctx_s3;
	logic [cbp_pkg::MSQ_W-1:0] msq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3.hit    <= hit_c;
			ctx_s3.in_box <= inside_c;
			ctx_s3.side   <= inside_c ? side_s2 : cbp_pkg::SIDE_LEFT;
			ctx_s3.vx     <= vx_s2;
			ctx_s3.vy     <= vy_s2;
			ctx_s3.ox_in  <= ox_s2;
			ctx_s3.oy_in  <= oy_s2;
			msq_s3        <= msq[cbp_pkg::MSQ_W-1:0];
		end
	end

	assign out_valid = v_s3;
	assign out_ctx   = ctx_s3;
	assign out_msq   = msq_s3;

endmodule

// ===== hdl/cbp_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module cbp_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  cbp_pkg::ctx_t                 in_ctx,
	input  logic [cbp_pkg::MSQ_W-1:0]     in_msq,
	output logic                          out_valid,
	output cbp_pkg::ctx_t                 out_ctx,
	output logic [cbp_pkg::LEN_W-1:0]     out_len
);

	localparam int N  = cbp_pkg::SQRT_STAGES;
	localparam int MW = cbp_pkg::MSQ_W;
	localparam int LW = cbp_pkg::LEN_W;
	localparam int RW = LW + 2;

	logic          v_s    [0:N];
	cbp_pkg::ctx_t ctx_s  [0:N];
	logic [RW-1:0] rem_s  [0:N];
	logic [LW-1:0] root_s [0:N];
	logic [MW-1:0] rest_s [0:N];

	assign v_s[0]    = in_valid;
	assign ctx_s[0]  = in_ctx;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rest_s[0] = in_msq;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [RW+1:0] sh;
		logic [RW+1:0] trial;
		logic          ge;

		assign sh    = {rem_s[k], rest_s[k][MW-1:MW-2]};
		assign trial = (RW + 2)'({root_s[k], 2'b01});
		assign ge    = sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[k+1]  <= ctx_s[k];
				rem_s[k+1]  <= ge ? RW'(sh - trial) : sh[RW-1:0];
				root_s[k+1] <= {root_s[k][LW-2:0], ge};
				rest_s[k+1] <= {rest_s[k][MW-3:0], 2'b00};
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_ctx   = ctx_s[N];
	assign out_len   = root_s[N];

endmodule

// ===== hdl/cbp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_div
// radius scaling: one multiply stage, then a two-lane pipelined rounding divide
// ----------------------------------------------------------------------------
module cbp_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  cbp_pkg::ctx_t                 in_ctx,
	input  logic [cbp_pkg::LEN_W-1:0]     in_len,
	input  logic [cbp_pkg::RADIUS_W-1:0]  radius,
	output logic                          out_valid,
	output cbp_pkg::ctx_t                 out_ctx,
	output logic [cbp_pkg::Q_W-1:0]       out_qx,
	output logic [cbp_pkg::Q_W-1:0]       out_qy
);

	localparam int N   = cbp_pkg::DIV_STAGES;
	localparam int NW  = cbp_pkg::NUM_W;
	localparam int LW  = cbp_pkg::LEN_W;
	localparam int DW  = LW + 1;
	localparam int RW  = DW + 1;
	localparam int QW  = cbp_pkg::Q_W;
	localparam int CW  = cbp_pkg::CW;
	localparam int MGW = CW - 1;
	localparam int PW  = MGW + cbp_pkg::RADIUS_W;

	// multiply stage: numerator 2*|v|*r + len, divisor 2*len (0 and 1 if len is 0)
	logic           len0;
	logic [CW-1:0]  absx, absy;
	logic [MGW-1:0] magx, magy;
	logic [PW-1:0]  prx, pry;
	logic [NW-1:0]  nx, ny;
	cbp_pkg::ctx_t  ctx_c;

	assign len0 = in_len == '0;
	assign absx = in_ctx.vx[CW-1] ? CW'(-in_ctx.vx) : CW'(in_ctx.vx);
	assign absy = in_ctx.vy[CW-1] ? CW'(-in_ctx.vy) : CW'(in_ctx.vy);
	assign magx = len0 ? '0 : absx[MGW-1:0];
	assign magy = len0 ? '0 : absy[MGW-1:0];
	assign prx  = magx * radius;
	assign pry  = magy * radius;
	assign nx   = NW'({prx, 1'b0}) + NW'(in_len);
	assign ny   = NW'({pry, 1'b0}) + NW'(in_len);

	always_comb begin
		ctx_c = in_ctx;
		if (len0) begin
			ctx_c.vx = '0;
			ctx_c.vy = '0;
		end
	end

	logic          v_s   [0:N];
	cbp_pkg::ctx_t ctx_s [0:N];
	logic [DW-1:0] den_s [0:N];
	logic [NW-1:0] num_m [0:1];
	logic [RW-1:0] rem_s  [0:1][0:N];
	logic [QW-1:0] rest_s [0:1][0:N];
	logic [QW-1:0] q_s    [0:1][0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s[0] <= ctx_c;
			den_s[0] <= len0 ? DW'(1) : {in_len, 1'b0};
			num_m[0] <= len0 ? '0 : nx;
			num_m[1] <= len0 ? '0 : ny;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[k+1] <= ctx_s[k];
				den_s[k+1] <= den_s[k];
			end
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		assign rem_s[l][0]  = num_m[l][NW-1:QW];
		assign rest_s[l][0] = num_m[l][QW-1:0];
		assign q_s[l][0]    = '0;

		for (genvar k = 0; k < N; k++) begin : g_stage
			logic [RW:0] sh;
			logic [RW:0] dd;
			logic        ge;

			assign sh = {rem_s[l][k], rest_s[l][k][QW-1]};
			assign dd = (RW + 1)'(den_s[k]);
			assign ge = sh >= dd;

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[l][k+1]  <= ge ? RW'(sh - dd) : sh[RW-1:0];
					rest_s[l][k+1] <= {rest_s[l][k][QW-2:0], 1'b0};
					q_s[l][k+1]    <= {q_s[l][k][QW-2:0], ge};
				end
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_ctx   = ctx_s[N];
	assign out_qx    = q_s[0][N];
	assign out_qy    = q_s[1][N];

endmodule

// ===== hdl/circle_box_push_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_box_push_out
// circle against axis-aligned box test with push-out offset
// ----------------------------------------------------------------------------
// Takes one word per cycle while item.ready is high and returns one result
// word per input word, in order. The datapath holds 3 front stages (gap
// vector, squares, hit and inside tests), 23 square-root stages (one root bit
// each), one radius multiply stage and 23 divide stages (one quotient bit
// each, x and y in parallel lanes). A two-word skid buffer sits on the
// output, so the pipeline keeps taking words while a finished result waits;
// item.ready drops only when both skid entries are full. Radius and inside
// threshold are written through cfg_we / cfg_index / cfg_data and must only
// change while the pipeline is empty.
module circle_box_push_out (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cbp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cbp_pkg::CFG_W-1:0]        cfg_data,
	cbp_item_if.sink                         item,
	cbp_result_if.source                     result
);

	localparam int OW = cbp_pkg::OFS_W;
	localparam int CW = cbp_pkg::CW;

	// configuration registers
	logic [cbp_pkg::RADIUS_W-1:0] radius_q;
	logic [cbp_pkg::THR_W-1:0]    thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= cbp_pkg::RADIUS_RST;
			thr_q    <= cbp_pkg::THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cbp_pkg::REG_RADIUS: radius_q <= cfg_data[cbp_pkg::RADIUS_W-1:0];
				cbp_pkg::REG_THR:    thr_q    <= cfg_data[cbp_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline advances while the skid buffer has a free entry
	logic [1:0] count_q;
	logic       en;

	assign en         = count_q != 2'd2;
	assign item.ready = en;

	logic                      fr_valid;
	cbp_pkg::ctx_t             fr_ctx;
	logic [cbp_pkg::MSQ_W-1:0] fr_msq;

	cbp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (item.valid),
		.in_word   (item.data),
		.radius    (radius_q),
		.thr       (thr_q),
		.out_valid (fr_valid),
		.out_ctx   (fr_ctx),
		.out_msq   (fr_msq)
	);

	logic                      sq_valid;
	cbp_pkg::ctx_t             sq_ctx;
	logic [cbp_pkg::LEN_W-1:0] sq_len;

	cbp_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.in_ctx    (fr_ctx),
		.in_msq    (fr_msq),
		.out_valid (sq_valid),
		.out_ctx   (sq_ctx),
		.out_len   (sq_len)
	);

	logic                    dv_valid;
	cbp_pkg::ctx_t           dv_ctx;
	logic [cbp_pkg::Q_W-1:0] dv_qx, dv_qy;

	cbp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_ctx    (sq_ctx),
		.in_len    (sq_len),
		.radius    (radius_q),
		.out_valid (dv_valid),
		.out_ctx   (dv_ctx),
		.out_qx    (dv_qx),
		.out_qy    (dv_qy)
	);

	// clip a wide offset to the coordinate range, flag in the top bit
	function automatic logic [CW:0] clip(input logic signed [OW-1:0] v);
		logic [CW:0] r;
		if (v > OW'(cbp_pkg::CW'(24'sh7FFFFF))) begin
			r = {1'b1, 24'h7FFFFF};
		end else if (v < -OW'(25'sh0800000)) begin
			r = {1'b1, 24'h800000};
		end else begin
			r = {1'b0, v[CW-1:0]};
		end
		return r;
	endfunction

	// outside case: v minus the rounded v*r/len, sign restored
	logic signed [OW-1:0] sx, sy, qx_e, qy_e, out_x, out_y, pick_x, pick_y;
	logic [CW:0]          cx, cy;
	cbp_pkg::out_word_t   fin;

	assign sx    = OW'(dv_ctx.vx);
	assign sy    = OW'(dv_ctx.vy);
	assign qx_e  = OW'({1'b0, dv_qx});
	assign qy_e  = OW'({1'b0, dv_qy});
	assign out_x = dv_ctx.vx[CW-1] ? sx + qx_e : sx - qx_e;
	assign out_y = dv_ctx.vy[CW-1] ? sy + qy_e : sy - qy_e;

	// inside case uses the nearest-side push
	assign pick_x = dv_ctx.in_box ? dv_ctx.ox_in : out_x;
	assign pick_y = dv_ctx.in_box ? dv_ctx.oy_in : out_y;
	assign cx     = clip(pick_x);
	assign cy     = clip(pick_y);

	always_comb begin
		fin = '0;
		if (dv_ctx.hit) begin
			fin.hit        = 1'b1;
			fin.offset_x   = cx[CW-1:0];
			fin.offset_y   = cy[CW-1:0];
			fin.was_inside = dv_ctx.in_box;
			fin.push_side  = dv_ctx.side;
			fin.saturated  = cx[CW] | cy[CW];
		end
	end

	// two-word skid buffer on the result side
	cbp_pkg::out_word_t buf_q [0:1];
	logic               wr_ptr_q, rd_ptr_q;
	logic               push, pop;

	assign push = en && dv_valid;
	assign pop  = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= fin;
		end
	end

	assign result.valid = count_q != 2'd0;
	assign result.data  = buf_q[rd_ptr_q];

endmodule
